[src/wall_edge_tile_coder_top_defines.svh]
// ----------------------------------------------------------------------------
// Wall edge tile coder assertion macros
// Shared property shapes for the port checker; clk and arst_n come from the
// module that uses them.
// ----------------------------------------------------------------------------
`ifndef WALL_EDGE_TILE_CODER_TOP_DEFINES_SVH
`define WALL_EDGE_TILE_CODER_TOP_DEFINES_SVH

// Same-cycle implication
`define WETC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define WETC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/wetc_pkg.sv]
// ----------------------------------------------------------------------------
// Wall edge tile coder package
// Shared types, register map and edge code constants.
// ----------------------------------------------------------------------------
package wetc_pkg;

	localparam int MAX_WIDTH_DEF = 32;

	// APB register map (byte address 4*index)
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;
	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_BASE   = 2'd2;

	localparam logic [5:0] WIDTH_RST  = 6'd32;
	localparam logic [7:0] HEIGHT_RST = 8'd24;
	localparam logic [7:0] BASE_RST   = 8'd0;

	// Edge code bits: a set bit marks a side with no wall neighbor
	localparam logic [3:0] CODE_LEFT   = 4'h1;
	localparam logic [3:0] CODE_RIGHT  = 4'h2;
	localparam logic [3:0] CODE_TOP    = 4'h4;
	localparam logic [3:0] CODE_BOTTOM = 4'h8;
	localparam logic [3:0] CODE_NONE   = 4'h0;

	typedef struct packed {
		logic [5:0] width_in_use;
		logic [7:0] height_in_use;
		logic [7:0] tile_base;
	} cfg_t;

	typedef struct packed {
		logic [7:0] tile_code;
		logic [4:0] cell_column;
		logic [7:0] cell_row;
		logic       last_of_run;
		logic       frame_done;
	} result_t;

	// One row store entry: one bit per bank, a bank select says which is the
	// pending row and which is the row above it
	typedef logic [1:0] entry_t;

endpackage

[src/wetc_cfg_regs.sv]
// ----------------------------------------------------------------------------
// Wall edge tile coder configuration registers
// APB register file for width, height and tile base.
// ----------------------------------------------------------------------------
module wetc_cfg_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [wetc_pkg::ADDR_W-1:0]  paddr,
	input  logic [wetc_pkg::DATA_W-1:0]  pwdata,
	output logic [wetc_pkg::DATA_W-1:0]  prdata,
	output logic                         pready,
	output wetc_pkg::cfg_t               cfg
);

	wetc_pkg::cfg_t cfg_q;
	logic           wr_en;
	logic [1:0]     reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign reg_idx = paddr[3:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.width_in_use  <= wetc_pkg::WIDTH_RST;
			cfg_q.height_in_use <= wetc_pkg::HEIGHT_RST;
			cfg_q.tile_base     <= wetc_pkg::BASE_RST;
		end else if (wr_en) begin
			case (reg_idx)
				wetc_pkg::REG_WIDTH:  cfg_q.width_in_use  <= pwdata[5:0];
				wetc_pkg::REG_HEIGHT: cfg_q.height_in_use <= pwdata[7:0];
				wetc_pkg::REG_BASE:   cfg_q.tile_base     <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			wetc_pkg::REG_WIDTH:  prdata = {26'd0, cfg_q.width_in_use};
			wetc_pkg::REG_HEIGHT: prdata = {24'd0, cfg_q.height_in_use};
			wetc_pkg::REG_BASE:   prdata = {24'd0, cfg_q.tile_base};
			default:              prdata = '0;
		endcase
	end

endmodule

[src/wetc_row_mem.sv]
// ----------------------------------------------------------------------------
// Wall edge tile coder row memory
// Two-bank row store, one entry per column, registered read, per-entry valid
// bits so that a frame end clears it at once.
// ----------------------------------------------------------------------------
module wetc_row_mem #(
	parameter int MAX_WIDTH = wetc_pkg::MAX_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [$clog2(MAX_WIDTH)-1:0]   wr_addr,
	input  wetc_pkg::entry_t               wr_data,
	input  logic                           rd_en,
	input  logic [$clog2(MAX_WIDTH):0]     rd_addr,
	output wetc_pkg::entry_t               rd_data,
	input  logic                           clear
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam logic [CW:0] DEPTH = (CW+1)'(MAX_WIDTH);

	wetc_pkg::entry_t       mem_q [MAX_WIDTH];
	logic [MAX_WIDTH-1:0]   valid_q;
	wetc_pkg::entry_t       rd_mem_s1;
	logic                   rd_ok_s1;
	logic                   rd_in_range;
	logic [CW-1:0]          rd_idx;

	assign rd_in_range = rd_addr < DEPTH;
	assign rd_idx      = rd_addr[CW-1:0];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en && rd_in_range) begin
			rd_mem_s1 <= mem_q[rd_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rd_ok_s1 <= 1'b0;
		end else begin
			if (clear) begin
				valid_q <= '0;
			end else if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_ok_s1 <= rd_in_range && valid_q[rd_idx];
			end
		end
	end

	// A never-written entry reads as an empty cell in both banks
	assign rd_data = rd_ok_s1 ? rd_mem_s1 : '0;

endmodule

[src/wetc_out_buf.sv]
// ----------------------------------------------------------------------------
// Wall edge tile coder output buffer
// Two-entry result queue that decouples the coder from the tile channel.
// ----------------------------------------------------------------------------
module wetc_out_buf (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  wetc_pkg::result_t  push_data,
	output logic               full,
	output logic               out_valid,
	input  logic               out_stall,
	output wetc_pkg::result_t  out_data
);

	wetc_pkg::result_t slot_q [2];
	logic [1:0]        cnt_q;
	logic              rd_ptr_q;
	logic              wr_ptr_q;
	logic              pop;

	assign full      = (cnt_q == 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign out_data  = slot_q[rd_ptr_q];
	assign pop       = out_valid && !out_stall;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= 2'd0;
			rd_ptr_q <= 1'b0;
			wr_ptr_q <= 1'b0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

[src/wall_edge_tile_coder_top.sv]
// ----------------------------------------------------------------------------
// Wall edge tile coder
// Four-neighbor autotile coder for a wall map fed one cell bit per beat.
// ----------------------------------------------------------------------------
// The block takes one map cell per clock, unless stalled, in raster order
// and gives tiles one row behind: the tile for cell (r, c) leaves when cell
// (r+1, c) goes in, so the first map row yields no tiles. A wall cell's code
// marks the sides with no wall neighbor (left 1, right 2, top 4, bottom 8),
// an empty cell codes 0, cells off the map count as empty, and the tile is
// tile_base plus the code, modulo 256. Sustained rate is one cell per cycle
// while the tile side keeps up; the limit is the single read port of the row
// memory, which runs two columns ahead of the scan so that each beat reads one
// entry and writes one. The map's final cell starts a flush of the last row:
// one tile per column, one per cycle unless the buffer is full, with cell_stall
// high; the last flush tile carries frame_done and the store is cleared at
// once by its valid bits, so no clearing pass follows. Results pass through a
// two-entry buffer, so a cell beat is taken while a finished tile waits.
// last_of_run marks the final tile caused by one cell beat. Width is clamped
// to 1..MAX_WIDTH and height to at least 1; write the registers only while the
// block is idle.
// ----------------------------------------------------------------------------
module wall_edge_tile_coder_top #(
	parameter int MAX_WIDTH = wetc_pkg::MAX_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// cell channel
	input  logic                         cell_valid,
	output logic                         cell_stall,
	input  logic                         wall_bit,
	// tile channel
	output logic                         tile_valid,
	input  logic                         tile_stall,
	output logic [7:0]                   tile_code,
	output logic [4:0]                   cell_column,
	output logic [7:0]                   cell_row,
	output logic                         last_of_run,
	output logic                         frame_done,
	// configuration
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [wetc_pkg::ADDR_W-1:0]  paddr,
	input  logic [wetc_pkg::DATA_W-1:0]  pwdata,
	output logic [wetc_pkg::DATA_W-1:0]  prdata,
	output logic                         pready
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam logic [6:0] MAXW7    = 7'(MAX_WIDTH);
	localparam logic [CW:0] RD_AHEAD = (CW+1)'(2);

	wetc_pkg::cfg_t     cfg;
	wetc_pkg::result_t  res;
	wetc_pkg::result_t  out_res;
	wetc_pkg::entry_t   rd_data;
	wetc_pkg::entry_t   wr_data;
	wetc_pkg::entry_t   win1_eff;

	// Scan position and window: win0 is the entry at col_q, win1 the next
	logic [CW-1:0]      col_q;
	logic [7:0]         row_q;
	logic               flush_q;
	logic               sel_q;
	logic               pend_q;
	logic               cprev_q;
	wetc_pkg::entry_t   win0_q;
	wetc_pkg::entry_t   win1_q;
	wetc_pkg::entry_t   head0_q;
	wetc_pkg::entry_t   head1_q;

	logic [6:0]         wid7;
	logic [6:0]         w_eff;
	logic [7:0]         h_eff;
	logic [6:0]         col7;
	logic [6:0]         col_inc7;
	logic               here_ok;
	logic               right_ok;
	logic               row_end;
	logic               frame_end;
	logic               buf_full;
	logic               accept_in;
	logic               flush_step;
	logic               flush_last;
	logic               step;
	logic               push;
	logic               cbit;
	logic               pbit;
	logic               rbit;
	logic               below;
	logic [3:0]         code;

	wetc_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Clamp the map size
	always_comb begin
		wid7 = {1'b0, cfg.width_in_use};
		if (wid7 == 7'd0) begin
			w_eff = 7'd1;
		end else if (wid7 > MAXW7) begin
			w_eff = MAXW7;
		end else begin
			w_eff = wid7;
		end
		h_eff = (cfg.height_in_use == 8'd0) ? 8'd1 : cfg.height_in_use;
	end

	assign col7      = 7'(col_q);
	assign col_inc7  = col7 + 7'd1;
	assign here_ok   = col7 < w_eff;
	assign right_ok  = col_inc7 < w_eff;
	assign row_end   = !right_ok;
	assign frame_end = row_end && (({1'b0, row_q} + 9'd1) >= {1'b0, h_eff});

	// Handshake: stall while the last row drains or the result buffer is full
	assign cell_stall = flush_q || buf_full;
	assign accept_in  = cell_valid && !cell_stall;
	assign flush_step = flush_q && !buf_full;
	assign flush_last = flush_step && row_end;
	assign step       = accept_in || flush_step;

	// The read issued on the last advance lands in rd_data and holds there
	assign win1_eff = pend_q ? rd_data : win1_q;

	// Pick the pending row bank and the row-above bank
	assign cbit = win0_q[sel_q];
	assign pbit = win0_q[~sel_q];
	assign rbit = win1_eff[sel_q];

	assign below = !flush_q && wall_bit && here_ok;

	// Clear the side bit wherever a wall neighbor stands
	always_comb begin
		code = wetc_pkg::CODE_NONE;
		if (cbit && here_ok) begin
			code = wetc_pkg::CODE_LEFT | wetc_pkg::CODE_RIGHT |
				wetc_pkg::CODE_TOP | wetc_pkg::CODE_BOTTOM;
			if (cprev_q && (col_q != '0)) begin
				code = code & ~wetc_pkg::CODE_LEFT;
			end
			if (rbit && right_ok) begin
				code = code & ~wetc_pkg::CODE_RIGHT;
			end
			if (pbit) begin
				code = code & ~wetc_pkg::CODE_TOP;
			end
			if (below) begin
				code = code & ~wetc_pkg::CODE_BOTTOM;
			end
		end
	end

	always_comb begin
		res.tile_code   = cfg.tile_base + {4'd0, code};
		res.cell_column = col7[4:0];
		res.cell_row    = flush_q ? row_q : (row_q - 8'd1);
		res.last_of_run = flush_q ? row_end : !frame_end;
		res.frame_done  = flush_q && row_end;
	end

	// No tiles while the first row streams in
	assign push = flush_step || (accept_in && (row_q != 8'd0));

	// Keep the pending-row bit, drop the new cell into the other bank
	assign wr_data = sel_q ? {win0_q[1], wall_bit} : {wall_bit, win0_q[0]};

	wetc_row_mem #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (accept_in),
		.wr_addr (col_q),
		.wr_data (wr_data),
		.rd_en   (step),
		.rd_addr ({1'b0, col_q} + RD_AHEAD),
		.rd_data (rd_data),
		.clear   (flush_last)
	);

	always_ff @(posedge clk) begin
		// Remember the first two entries of this row for the wrap to column 0
		if (accept_in && (col_q == CW'(0))) begin
			head0_q <= wr_data;
		end
		if (accept_in && (col_q == CW'(1))) begin
			head1_q <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= 8'd0;
			flush_q <= 1'b0;
			sel_q   <= 1'b0;
			pend_q  <= 1'b0;
			cprev_q <= 1'b0;
			win0_q  <= '0;
			win1_q  <= '0;
		end else if (flush_last) begin
			// Frame done: rewind to an empty map
			col_q   <= '0;
			row_q   <= 8'd0;
			flush_q <= 1'b0;
			pend_q  <= 1'b0;
			cprev_q <= 1'b0;
			win0_q  <= '0;
			win1_q  <= '0;
		end else if (accept_in && row_end) begin
			// Row wrap: swap banks, reload the window from the head entries
			col_q   <= '0;
			sel_q   <= ~sel_q;
			pend_q  <= 1'b0;
			cprev_q <= cbit;
			if (col_q == CW'(0)) begin
				win0_q <= wr_data;
				win1_q <= win1_eff;
			end else if (col_q == CW'(1)) begin
				win0_q <= head0_q;
				win1_q <= wr_data;
			end else begin
				win0_q <= head0_q;
				win1_q <= head1_q;
			end
			if (frame_end) begin
				flush_q <= 1'b1;
			end else begin
				row_q <= row_q + 8'd1;
			end
		end else if (step) begin
			// Advance one column
			col_q   <= col_q + CW'(1);
			win0_q  <= win1_eff;
			cprev_q <= cbit;
			pend_q  <= 1'b1;
		end
	end

	wetc_out_buf u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (res),
		.full      (buf_full),
		.out_valid (tile_valid),
		.out_stall (tile_stall),
		.out_data  (out_res)
	);

	assign tile_code   = out_res.tile_code;
	assign cell_column = out_res.cell_column;
	assign cell_row    = out_res.cell_row;
	assign last_of_run = out_res.last_of_run;
	assign frame_done  = out_res.frame_done;

endmodule

[src/wetc_checker.sv]
// ----------------------------------------------------------------------------
// Wall edge tile coder port checker
// Watches the tile channel of the top level; bound in below.
// ----------------------------------------------------------------------------
`include "wall_edge_tile_coder_top_defines.svh"

module wetc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       tile_valid,
	input logic       tile_stall,
	input logic [7:0] tile_code,
	input logic [4:0] cell_column,
	input logic [7:0] cell_row,
	input logic       last_of_run,
	input logic       frame_done
);

	// A stalled tile beat holds
	`WETC_ASSERT_NEXT(a_tile_hold, tile_valid && tile_stall, tile_valid && $stable(tile_code) && $stable(cell_column) && $stable(cell_row) && $stable(last_of_run) && $stable(frame_done), "tile beat changed under stall")

	// The frame's final tile also ends its run
	`WETC_ASSERT_NOW(a_done_last, tile_valid && frame_done, last_of_run, "frame_done without last_of_run")

	// Rows never reach 255
	`WETC_ASSERT_NOW(a_row_range, tile_valid, cell_row != 8'd255, "tile row out of range")

endmodule

bind wall_edge_tile_coder_top wetc_checker u_wetc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.tile_valid  (tile_valid),
	.tile_stall  (tile_stall),
	.tile_code   (tile_code),
	.cell_column (cell_column),
	.cell_row    (cell_row),
	.last_of_run (last_of_run),
	.frame_done  (frame_done)
);

[test/wall_edge_tile_coder_top_tb.sv]
// ----------------------------------------------------------------------------
// Wall edge tile coder testbench
// Feeds wall maps one cell per beat and checks every tile beat against a
// cycle-free model of the edge coder that runs alongside the block.
// ----------------------------------------------------------------------------
// Each accepted cell beat advances a local copy of the two row stores and the
// position counters and queues the tiles that the beat causes, flush included.
// Every tile beat is then compared field by field with the oldest queued tile.
// Registers are written over the configuration port only once all queued tiles
// have come back. Both channels idle at random, with one quiet frame, a long
// hold-off on the tile side that backs the block up into the cell side, and
// pauses that let the tile queue run dry.
// ----------------------------------------------------------------------------
module wall_edge_tile_coder_top_tb;

	localparam int CYCLE_LIMIT   = 300000;
	localparam int SETTLE_CYCLES = 8;
	localparam int TAIL_CYCLES   = 48;
	localparam int HOLD_CYCLES   = 300;
	localparam int RANDOM_CELLS  = 180;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          cell_valid = 1'b0;
	logic                          cell_stall;
	logic                          wall_bit = 1'b0;
	logic                          tile_valid;
	logic                          tile_stall = 1'b0;
	logic [7:0]                    tile_code;
	logic [4:0]                    cell_column;
	logic [7:0]                    cell_row;
	logic                          last_of_run;
	logic                          frame_done;
	logic                          psel = 1'b0;
	logic                          penable = 1'b0;
	logic                          pwrite = 1'b0;
	logic [wetc_pkg::ADDR_W-1:0]   paddr = '0;
	logic [wetc_pkg::DATA_W-1:0]   pwdata = '0;
	logic [wetc_pkg::DATA_W-1:0]   prdata;
	logic                          pready;

	// Model copy of the registers
	logic [5:0]  cfg_width  = wetc_pkg::WIDTH_RST;
	logic [7:0]  cfg_height = wetc_pkg::HEIGHT_RST;
	logic [7:0]  cfg_base   = wetc_pkg::BASE_RST;

	// Model copy of the row stores and position counters
	logic [31:0] row_above = '0;
	logic [31:0] row_pending = '0;
	logic [4:0]  next_col = '0;
	logic [7:0]  next_row = '0;

	wetc_pkg::result_t pending_tiles[$];
	int          bad_beats = 0;
	int          cycle_count = 0;
	int          hold_left = 0;
	bit          no_idle = 1'b0;

	wall_edge_tile_coder_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cell_valid  (cell_valid),
		.cell_stall  (cell_stall),
		.wall_bit    (wall_bit),
		.tile_valid  (tile_valid),
		.tile_stall  (tile_stall),
		.tile_code   (tile_code),
		.cell_column (cell_column),
		.cell_row    (cell_row),
		.last_of_run (last_of_run),
		.frame_done  (frame_done),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Watchdog: end the run if the block hangs
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("wall_edge_tile_coder_top_tb: errors");
			$finish;
		end
	end

	// Tile side: a hold-off request wins, then the quiet flag, else random stall
	always @(negedge clk) begin
		if (hold_left > 0) begin
			tile_stall <= 1'b1;
			hold_left = hold_left - 1;
		end else if (no_idle) begin
			tile_stall <= 1'b0;
		end else begin
			tile_stall <= ($urandom_range(0, 99) < 24);
		end
	end

	// Cells outside the row read as empty
	function automatic bit cell_at(logic [31:0] rowbits, int c, int w);
		if (c < 0 || c >= w) return 1'b0;
		return rowbits[c];
	endfunction

	function automatic logic [3:0] edge_mask(logic [31:0] above, logic [31:0] here,
			bit below, int c, int w);
		logic [3:0] m;
		if (!cell_at(here, c, w)) return wetc_pkg::CODE_NONE;
		m = wetc_pkg::CODE_LEFT | wetc_pkg::CODE_RIGHT | wetc_pkg::CODE_TOP |
			wetc_pkg::CODE_BOTTOM;
		if (c > 0 && cell_at(here, c - 1, w)) m &= ~wetc_pkg::CODE_LEFT;
		if (cell_at(here, c + 1, w)) m &= ~wetc_pkg::CODE_RIGHT;
		if (cell_at(above, c, w)) m &= ~wetc_pkg::CODE_TOP;
		if (below) m &= ~wetc_pkg::CODE_BOTTOM;
		return m;
	endfunction

	function automatic void queue_tile(logic [3:0] m, int c, int r, bit last, bit done);
		wetc_pkg::result_t t;
		t.tile_code   = cfg_base + {4'h0, m};
		t.cell_column = c[4:0];
		t.cell_row    = r[7:0];
		t.last_of_run = last;
		t.frame_done  = done;
		pending_tiles.push_back(t);
	endfunction

	// Advance the model by one accepted cell and queue the tiles it causes
	function automatic void code_cell(bit wall);
		int w;
		int h;
		int c;
		int r;
		bit row_end;
		bit frame_end;
		logic [31:0] swap;
		w = (cfg_width == 0) ? 1 : ((cfg_width > 32) ? 32 : int'(cfg_width));
		h = (cfg_height == 0) ? 1 : int'(cfg_height);
		c = int'(next_col);
		r = int'(next_row);
		row_end = (c + 1 >= w);
		frame_end = row_end && (r + 1 >= h);
		if (r > 0)
			queue_tile(edge_mask(row_above, row_pending, wall && c < w, c, w),
				c, r - 1, !frame_end, 1'b0);
		row_above[c] = wall;
		if (!row_end) begin
			next_col = 5'(c + 1);
			return;
		end
		swap = row_above;
		row_above = row_pending;
		row_pending = swap;
		next_col = '0;
		if (!frame_end) begin
			next_row = 8'(r + 1);
			return;
		end
		// Final cell: flush the last row
		for (int k = 0; k < w; k++)
			queue_tile(edge_mask(row_above, row_pending, 1'b0, k, w), k, r,
				k + 1 == w, k + 1 == w);
		row_above = '0;
		row_pending = '0;
		next_col = '0;
		next_row = '0;
	endfunction

	function automatic void compare_field(string name, int want, int got);
		if (want != got) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			bad_beats++;
		end
	endfunction

	// Predict on every cell beat, then check every tile beat, in one process
	always @(posedge clk) begin : tile_monitor
		wetc_pkg::result_t want;
		if (arst_n) begin
			if (cell_valid && !cell_stall) code_cell(wall_bit);
			if (tile_valid && !tile_stall) begin
				if (pending_tiles.size() == 0) begin
					$error("tile beat with no tile queued: code %0d col %0d row %0d",
						tile_code, cell_column, cell_row);
					bad_beats++;
				end else begin
					want = pending_tiles.pop_front();
					compare_field("tile_code", want.tile_code, tile_code);
					compare_field("cell_column", want.cell_column, cell_column);
					compare_field("cell_row", want.cell_row, cell_row);
					compare_field("last_of_run", want.last_of_run, last_of_run);
					compare_field("frame_done", want.frame_done, frame_done);
				end
			end
		end
	end

	// One configuration access: setup, then access until pready
	task automatic reg_access(bit wr, logic [1:0] idx, logic [31:0] wdata,
			output logic [31:0] rdata);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= {idx, 2'b00};
		pwdata  <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		if (wr) begin
			case (idx)
				wetc_pkg::REG_WIDTH:  cfg_width  = wdata[5:0];
				wetc_pkg::REG_HEIGHT: cfg_height = wdata[7:0];
				wetc_pkg::REG_BASE:   cfg_base   = wdata[7:0];
				default: ;
			endcase
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic write_map(int w, int h, int base);
		logic [31:0] unused;
		reg_access(1'b1, wetc_pkg::REG_WIDTH, w, unused);
		reg_access(1'b1, wetc_pkg::REG_HEIGHT, h, unused);
		reg_access(1'b1, wetc_pkg::REG_BASE, base, unused);
	endtask

	task automatic check_reg(logic [1:0] idx, logic [31:0] want);
		logic [31:0] got;
		reg_access(1'b0, idx, '0, got);
		if (got !== want) begin
			$error("register %0d: expected %0d, actual %0d", idx, want, got);
			bad_beats++;
		end
	endtask

	// Offer one cell; idle first at random; return at the accepting edge
	task automatic send_cell(bit wall);
		while (!no_idle && $urandom_range(0, 99) < 24) begin
			@(negedge clk);
			cell_valid <= 1'b0;
		end
		@(negedge clk);
		cell_valid <= 1'b1;
		wall_bit   <= wall;
		do @(posedge clk); while (cell_stall);
	endtask

	// Bits go in raster order starting from bit 0
	task automatic send_bits(logic [15:0] bits, int n);
		for (int i = 0; i < n; i++) send_cell(bits[i]);
	endtask

	task automatic send_random(int n, int density);
		for (int i = 0; i < n; i++) send_cell($urandom_range(0, 99) < density);
	endtask

	// Drop valid and let every queued tile come back
	task automatic drain_tiles();
		@(negedge clk);
		cell_valid <= 1'b0;
		while (pending_tiles.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic test_reset_values();
		check_reg(wetc_pkg::REG_WIDTH, 32'(wetc_pkg::WIDTH_RST));
		check_reg(wetc_pkg::REG_HEIGHT, 32'(wetc_pkg::HEIGHT_RST));
		check_reg(wetc_pkg::REG_BASE, 32'(wetc_pkg::BASE_RST));
	endtask

	// Upper data bits are dropped; height zero acts as one row
	task automatic test_register_map();
		logic [31:0] unused;
		reg_access(1'b1, wetc_pkg::REG_WIDTH, 32'hffff_ffc5, unused);
		reg_access(1'b1, wetc_pkg::REG_HEIGHT, 32'habcd_0100, unused);
		reg_access(1'b1, wetc_pkg::REG_BASE, 32'h1234_56ff, unused);
		check_reg(wetc_pkg::REG_WIDTH, 32'd5);
		check_reg(wetc_pkg::REG_HEIGHT, 32'd0);
		check_reg(wetc_pkg::REG_BASE, 32'd255);
		send_bits(16'b1_1011, 5);
		drain_tiles();
	endtask

	// One-cell maps, width zero clamped to one, tile base wrapping past 255
	task automatic test_single_cell();
		write_map(1, 1, 0);
		send_cell(1'b1);
		send_cell(1'b0);
		drain_tiles();
		write_map(0, 0, 255);
		send_cell(1'b1);
		drain_tiles();
	endtask

	// Solid block with a hole below the center, then a diagonal pair
	task automatic test_edge_codes();
		write_map(3, 3, 8'h10);
		send_bits(16'b101_111_111, 9);
		drain_tiles();
		write_map(2, 2, 8'hf8);
		send_bits(16'b1001, 4);
		drain_tiles();
	endtask

	// Shrink the map mid-frame: past the last column and past the last row
	task automatic test_mid_frame();
		write_map(4, 255, 8'h21);
		send_bits(16'b11_0111_1110, 10);
		drain_tiles();
		write_map(2, 2, 8'h21);
		send_cell(1'b1);
		drain_tiles();
	endtask

	// Hold the tile side long enough that the block backs up into the cell side
	task automatic test_backpressure();
		write_map(8, 6, 8'h40);
		no_idle = 1'b1;
		hold_left = HOLD_CYCLES;
		send_random(48, 60);
		no_idle = 1'b0;
		drain_tiles();
	endtask

	task automatic test_random_frames();
		int sent;
		int frame;
		int wr;
		int hr;
		int base;
		int weff;
		int heff;
		int density;
		sent = 0;
		frame = 0;
		while (sent < RANDOM_CELLS) begin
			case ($urandom_range(0, 9))
				0: begin wr = 0; hr = $urandom_range(1, 4); end
				1: begin wr = $urandom_range(33, 63); hr = $urandom_range(1, 2); end
				2: begin wr = 32; hr = $urandom_range(1, 2); end
				3: begin wr = $urandom_range(1, 6); hr = 0; end
				default: begin wr = $urandom_range(1, 8); hr = $urandom_range(1, 6); end
			endcase
			// One quiet frame with no idling on either side
			if (frame == 4) begin
				wr = 8;
				hr = 8;
			end
			base = $urandom_range(0, 255);
			if ($urandom_range(0, 4) == 0) base = $urandom_range(0, 1) ? 255 : 0;
			case ($urandom_range(0, 2))
				0: density = 15;
				1: density = 50;
				default: density = 90;
			endcase
			weff = (wr == 0) ? 1 : ((wr > 32) ? 32 : wr);
			heff = (hr == 0) ? 1 : hr;
			write_map(wr, hr, base);
			no_idle = (frame == 4);
			send_random(weff * heff, density);
			no_idle = 1'b0;
			drain_tiles();
			sent += weff * heff;
			frame++;
		end
	endtask

	initial begin
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		test_reset_values();
		test_single_cell();
		test_edge_codes();
		test_register_map();
		test_mid_frame();
		test_backpressure();
		test_random_frames();
		drain_tiles();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (bad_beats == 0 && pending_tiles.size() == 0) begin
			$display("wall_edge_tile_coder_top_tb: clean");
		end else begin
			$display("wall_edge_tile_coder_top_tb: errors");
		end
		$finish;
	end

endmodule
